### rtl/rc4_keystream_generator_macros.svh
// assertion helpers shared by the rc4 rtl
`ifndef RC4_KEYSTREAM_GENERATOR_MACROS_SVH
`define RC4_KEYSTREAM_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define RC4_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc4 check failed");

// next-cycle implication, disabled during reset
`define RC4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc4 check failed");

`endif

### rtl/rc4_pkg.sv
package rc4_pkg;

   localparam int unsigned IDX_W    = 8;
   localparam int unsigned DEPTH    = 256;
   localparam int unsigned KEY_W    = 96;
   localparam int unsigned IV_W     = 32;
   localparam int unsigned SEED_W   = KEY_W + IV_W;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 64;

   typedef logic [IDX_W-1:0] byte_type;

   // input operation codes
   localparam logic OP_REKEY    = 1'b0;
   localparam logic OP_GENERATE = 1'b1;

   // register select, taken from address bit 3 (registers at 8-byte stride)
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

endpackage

### rtl/rc4_if.sv
interface rc4_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [rc4_pkg::IV_W-1:0]   iv;

   modport source (output valid, output op, output iv, input ready);
   modport sink   (input valid, input op, input iv, output ready);
endinterface

interface rc4_rsp_if;
   logic                valid;
   logic                ready;
   rc4_pkg::byte_type   keystream_byte;
   logic                not_ready;

   modport source (output valid, output keystream_byte, output not_ready, input ready);
   modport sink   (input valid, input keystream_byte, input not_ready, output ready);
endinterface

### rtl/rc4_keystream_generator.sv
// rc4 keystream engine over one 256 x 8 table, 1 write + 1 read port, registered read
// generate beat: 4 table steps G0 to G3, G3 holding while the output register is full, then idle
// generate before the first rekey: a not_ready beat is loaded from the error state, then idle
// rekey beat: 256 fill steps, 256 schedule steps of KS0/KS1/KS2, an end write, then idle
// reset (synchronous, active high) clears keys, indices, keyed flag and the output valid flag;
// input is held off during reset, table is not cleared, every rekey rewrites the identity
`include "rc4_keystream_generator_macros.svh"

module rc4_keystream_generator (
   input  logic                          clock,
   input  logic                          reset,
   rc4_req_if.sink                       req_bus,
   rc4_rsp_if.source                     rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rc4_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [rc4_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [rc4_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   // sequencer codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FILL = 4'd1;  // identity sweep
   localparam logic [3:0] ST_KS0  = 4'd2;  // read s[k], retire previous s[j] write
   localparam logic [3:0] ST_KS1  = 4'd3;  // update j, read s[j]
   localparam logic [3:0] ST_KS2  = 4'd4;  // write s[k]
   localparam logic [3:0] ST_KEND = 4'd5;  // last s[j] write
   localparam logic [3:0] ST_G0   = 4'd6;  // bump i, read s[i]
   localparam logic [3:0] ST_G1   = 4'd7;  // update j, read s[j]
   localparam logic [3:0] ST_G2   = 4'd8;  // write s[i], read s[t]
   localparam logic [3:0] ST_G3   = 4'd9;  // write s[j], present byte
   localparam logic [3:0] ST_ERR  = 4'd10; // generate before any rekey

   localparam int unsigned KH_W = rc4_pkg::KEY_W - rc4_pkg::CSR_DW;

   // configuration registers
   logic [rc4_pkg::CSR_DW-1:0] key_low_ff,  key_low_in;
   logic [KH_W-1:0]            key_high_ff, key_high_in;

   // control
   logic [3:0]          state_ff, state_in;
   logic                keyed_ff, keyed_in;
   rc4_pkg::byte_type   i_ff, i_in;     // also the schedule counter k
   rc4_pkg::byte_type   j_ff, j_in;
   logic                pend_ff, pend_in; // s[j] write still owed by the schedule
   logic                fwd_ff, fwd_in;   // s[k] read collided with that write
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath holding registers
   logic [rc4_pkg::SEED_W-1:0] seed_ff, seed_in;
   rc4_pkg::byte_type          sk_ff, sk_in;   // s[k] in schedule, s[i] in generate
   rc4_pkg::byte_type          sj_ff, sj_in;
   rc4_pkg::byte_type          t_ff, t_in;
   rc4_pkg::byte_type          ks_ff, ks_in;
   logic                       nr_ff, nr_in;

   // permutation table
   rc4_pkg::byte_type perm_mem [rc4_pkg::DEPTH];
   rc4_pkg::byte_type rdata_ff;
   logic              mem_we, mem_re;
   rc4_pkg::byte_type mem_waddr, mem_wdata, mem_raddr;

   logic req_beat, rekey_beat, rsp_load, csr_write;
   rc4_pkg::byte_type sk_cur, seed_byte, j_next;

   assign req_beat   = req_bus.valid && req_bus.ready;
   assign rekey_beat = req_beat && (req_bus.op == rc4_pkg::OP_REKEY);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == rc4_pkg::REG_KEY_HIGH)
                       ? {{(rc4_pkg::CSR_DW-KH_W){1'b0}}, key_high_ff} : key_low_ff;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_write) begin
         unique case (csr_paddr[3])
            rc4_pkg::REG_KEY_LOW:  key_low_in  = csr_pwdata;
            rc4_pkg::REG_KEY_HIGH: key_high_in = csr_pwdata[KH_W-1:0];
            default:               key_low_in  = key_low_ff;
         endcase
      end
   end

   // ---- handshakes ----
   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;
   // output register takes a byte when empty or being drained
   assign rsp_load = ((state_ff == ST_G3) || (state_ff == ST_ERR))
                     && (!rsp_valid_ff || rsp_bus.ready);

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.keystream_byte = ks_ff;
   assign rsp_bus.not_ready      = nr_ff;

   // schedule helpers: forwarded s[k] and the seed byte for k mod 16
   assign sk_cur    = fwd_ff ? sk_ff : rdata_ff;
   assign seed_byte = seed_ff[{i_ff[3:0], 3'b000} +: rc4_pkg::IDX_W];
   assign j_next    = (state_ff == ST_KS1) ? (j_ff + sk_cur + seed_byte) : (j_ff + rdata_ff);

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      keyed_in     = keyed_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pend_in      = pend_ff;
      fwd_in       = 1'b0;
      seed_in      = seed_ff;
      sk_in        = sk_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      ks_in        = ks_ff;
      nr_in        = nr_ff;
      mem_we       = 1'b0;
      mem_waddr    = i_ff;
      mem_wdata    = sk_ff;
      mem_re       = 1'b0;
      mem_raddr    = i_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_bus.op == rc4_pkg::OP_REKEY) begin
                  seed_in  = {req_bus.iv, key_high_ff, key_low_ff};
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_FILL;
               end else if (keyed_ff) begin
                  state_in = ST_G0;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = i_ff;
            i_in      = i_ff + rc4_pkg::byte_type'(1);
            pend_in   = 1'b0;
            if (i_ff == '1) state_in = ST_KS0;
         end
         ST_KS0: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff;
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = j_ff;
               mem_wdata = sk_ff;
               fwd_in    = (i_ff == j_ff);
            end
            state_in = ST_KS1;
         end
         ST_KS1: begin
            sk_in     = sk_cur;
            j_in      = j_next;
            mem_re    = 1'b1;
            mem_raddr = j_next;
            state_in  = ST_KS2;
         end
         ST_KS2: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rdata_ff;
            i_in      = i_ff + rc4_pkg::byte_type'(1);
            pend_in   = 1'b1;
            state_in  = (i_ff == '1) ? ST_KEND : ST_KS0;
         end
         ST_KEND: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = sk_ff;
            pend_in   = 1'b0;
            j_in      = '0;
            keyed_in  = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_G0: begin
            i_in      = i_ff + rc4_pkg::byte_type'(1);
            mem_re    = 1'b1;
            mem_raddr = i_ff + rc4_pkg::byte_type'(1);
            state_in  = ST_G1;
         end
         ST_G1: begin
            sk_in     = rdata_ff;
            j_in      = j_next;
            mem_re    = 1'b1;
            mem_raddr = j_next;
            state_in  = ST_G2;
         end
         ST_G2: begin
            sj_in     = rdata_ff;
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rdata_ff;
            t_in      = sk_ff + rdata_ff;
            mem_re    = 1'b1;
            mem_raddr = sk_ff + rdata_ff;
            state_in  = ST_G3;
         end
         ST_G3: begin
            // rewriting s[j] while stalled is harmless
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = sk_ff;
            if (rsp_load) begin
               // s[t] read saw the table before the swap, patch the two swapped slots
               if (t_ff == i_ff)      ks_in = sj_ff;
               else if (t_ff == j_ff) ks_in = sk_ff;
               else                   ks_in = rdata_ff;
               nr_in        = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (rsp_load) begin
               ks_in        = '0;
               nr_in        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keyed_ff     <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         pend_ff      <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         keyed_ff     <= keyed_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      sk_ff   <= sk_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      ks_ff   <= ks_in;
      nr_ff   <= nr_in;
   end

   // table: read returns the contents before a same-cycle write
   always_ff @(posedge clock) begin
      if (mem_we) perm_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rdata_ff <= perm_mem[mem_raddr];
   end

   // ---- checks ----
   // generation only ever runs on a keyed table
   `RC4_ASSERT_NOW(a_gen_keyed, clock, reset, state_ff == ST_G0, keyed_ff)
   // a rekey beat starts the identity sweep from entry zero
   `RC4_ASSERT_NEXT(a_rekey_fill, clock, reset, rekey_beat, state_ff == ST_FILL && i_ff == '0)
   // an owed schedule write is only retired right after a schedule write step
   `RC4_ASSERT_NOW(a_pend_order, clock, reset, state_ff == ST_KS0 && pend_ff, $past(state_ff) == ST_KS2)

endmodule

### test/tb_rc4_keystream_generator.sv
`timescale 1ns / 100ps

module tb_rc4_keystream_generator;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   // a rekey keeps the engine busy with no beat to show for it
   localparam int unsigned SETTLE_CYCLES = 1100;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      rc4_pkg::byte_type ks;
      logic              nr;
   } keystream_beat_type;

   // tracks the cipher state and the keystream beats still owed by the engine
   class keystream_scoreboard_type;
      rc4_pkg::byte_type   perm [rc4_pkg::DEPTH];
      rc4_pkg::byte_type   idx_i;
      rc4_pkg::byte_type   idx_j;
      bit                  keyed;
      logic [63:0]         key_lo;
      logic [31:0]         key_hi;
      keystream_beat_type  owed_beats [$];
      int unsigned         mismatches;

      function new();
         key_lo     = '0;
         key_hi     = '0;
         idx_i      = '0;
         idx_j      = '0;
         keyed      = 1'b0;
         mismatches = 0;
         for (int k = 0; k < rc4_pkg::DEPTH; k++) perm[k] = rc4_pkg::byte_type'(k);
      endfunction

      function void swap_perm(rc4_pkg::byte_type a, rc4_pkg::byte_type b);
         rc4_pkg::byte_type t;
         t       = perm[a];
         perm[a] = perm[b];
         perm[b] = t;
      endfunction

      // seed = 12 key bytes then 4 iv bytes, standard 256-step schedule from identity
      function void schedule_key(logic [rc4_pkg::IV_W-1:0] iv);
         rc4_pkg::byte_type seed [16];
         rc4_pkg::byte_type j;
         for (int k = 0; k < 8; k++) seed[k] = key_lo[8*k +: 8];
         for (int k = 0; k < 4; k++) begin
            seed[8+k]  = key_hi[8*k +: 8];
            seed[12+k] = iv[8*k +: 8];
         end
         for (int k = 0; k < rc4_pkg::DEPTH; k++) perm[k] = rc4_pkg::byte_type'(k);
         j = '0;
         for (int k = 0; k < rc4_pkg::DEPTH; k++) begin
            j = j + perm[k] + seed[k % 16];
            swap_perm(rc4_pkg::byte_type'(k), j);
         end
         idx_i = '0;
         idx_j = '0;
         keyed = 1'b1;
      endfunction

      function void note_request(logic op, logic [rc4_pkg::IV_W-1:0] iv);
         keystream_beat_type beat;
         rc4_pkg::byte_type  sum;
         if (op == rc4_pkg::OP_REKEY) begin
            schedule_key(iv);
            return;
         end
         if (!keyed) begin
            beat.ks = '0;
            beat.nr = 1'b1;
         end else begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + perm[idx_i];
            swap_perm(idx_i, idx_j);
            sum     = perm[idx_i] + perm[idx_j];
            beat.ks = perm[sum];
            beat.nr = 1'b0;
         end
         owed_beats.push_back(beat);
      endfunction

      function void check_response(rc4_pkg::byte_type ks, logic nr);
         keystream_beat_type want;
         if (owed_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: keystream beat with none owed: byte %02h not_ready %b",
                        $realtime, ks, nr);
            return;
         end
         want = owed_beats.pop_front();
         if (ks !== want.ks || nr !== want.nr) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: keystream mismatch: expected %02h/%b, got %02h/%b",
                        $realtime, want.ks, want.nr, ks, nr);
         end
      endfunction

      function int unsigned outstanding();
         return owed_beats.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [rc4_pkg::CSR_AW-1:0]   csr_paddr;
   logic [rc4_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [rc4_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   rc4_req_if req_if ();
   rc4_rsp_if rsp_if ();

   keystream_scoreboard_type sb = new;

   int unsigned cycle_count   = 0;
   int unsigned tx_idle_pct   = 0;   // chance per cycle that the sender holds back
   int unsigned rx_idle_pct   = 0;   // chance per cycle that the receiver holds off
   int unsigned hold_requests = 0;   // bumped by the main flow, served by the receiver

   rc4_keystream_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake or a lost beat ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rc4_keystream_generator verification failed");
         $finish;
      end
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.keystream_byte, rsp_if.not_ready);
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.op, req_if.iv);
      end
   end

   // receiver: random backpressure, plus a long hold-off whenever one is requested
   initial begin
      int unsigned hold_left;
      int unsigned hold_served;
      hold_left    = 0;
      hold_served  = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // offer one beat, with random gaps ahead of it, and return once it is taken
   task automatic send_item(logic op, logic [rc4_pkg::IV_W-1:0] iv);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op    <= op;
      req_if.iv    <= iv;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // stop offering, wait for every owed beat, then let any rekey run out
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // two-phase apb write; registers sit at an 8-byte stride
   task automatic write_csr(logic sel, logic [rc4_pkg::CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 3'b000};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (sel == rc4_pkg::REG_KEY_LOW)
         sb.key_lo = data;
      else
         sb.key_hi = data[31:0];
   endtask

   // new random key, a rekey, then a stream of mostly generate beats
   task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned count,
                            int unsigned rekey_odds, bit with_hold);
      settle();
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      write_csr(rc4_pkg::REG_KEY_LOW, {$urandom, $urandom});
      write_csr(rc4_pkg::REG_KEY_HIGH, {$urandom, $urandom});
      send_item(rc4_pkg::OP_REKEY, $urandom);
      for (int unsigned k = 0; k < count; k++) begin
         // receiver stalls long enough that the engine backs up into the sender
         if (with_hold && k == count / 3) hold_requests++;
         if ($urandom_range(rekey_odds - 1) == 0)
            send_item(rc4_pkg::OP_REKEY, $urandom);
         else
            send_item(rc4_pkg::OP_GENERATE, $urandom);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.op    = rc4_pkg::OP_REKEY;
      req_if.iv    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      tx_idle_pct  = 27;
      rx_idle_pct  = 64;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // generate before any rekey: not_ready beats, state untouched
      send_item(rc4_pkg::OP_GENERATE, $urandom);
      send_item(rc4_pkg::OP_GENERATE, 32'hFFFF_FFFF);

      // all-zero seed from reset keys and a zero iv
      send_item(rc4_pkg::OP_REKEY, 32'h0000_0000);
      repeat (4) send_item(rc4_pkg::OP_GENERATE, $urandom);

      // all-ones seed
      settle();
      write_csr(rc4_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(rc4_pkg::REG_KEY_HIGH, {$urandom, 32'hFFFF_FFFF});
      send_item(rc4_pkg::OP_REKEY, 32'hFFFF_FFFF);
      repeat (4) send_item(rc4_pkg::OP_GENERATE, $urandom);

      // mixed extremes, then a rekey in the middle of a stream
      settle();
      write_csr(rc4_pkg::REG_KEY_LOW, 64'h0000_0000_0000_0000);
      write_csr(rc4_pkg::REG_KEY_HIGH, 64'hFFFF_FFFF_0000_0000);
      send_item(rc4_pkg::OP_REKEY, 32'h8000_0001);
      repeat (3) send_item(rc4_pkg::OP_GENERATE, $urandom);
      send_item(rc4_pkg::OP_REKEY, 32'h0000_0000);
      repeat (3) send_item(rc4_pkg::OP_GENERATE, $urandom);

      // slow receiver, then slow sender, then full rate with a long run past index wrap
      run_phase(27, 64, 100, 25, 1'b1);
      run_phase(64, 27, 100, 25, 1'b0);
      run_phase(0, 0, 250, 200, 1'b1);

      settle();
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("rc4_keystream_generator verification clean");
      else
         $display("rc4_keystream_generator verification failed");
      $finish;
   end

endmodule
